// ===== design/thumbnail_cut_scorer_unit_defines.svh =====
// assertion macros for the thumbnail cut scorer
`ifndef THUMBNAIL_CUT_SCORER_UNIT_DEFINES_SVH
`define THUMBNAIL_CUT_SCORER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define TCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `TCS_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define TCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/thumbcut_pkg.sv =====
package thumbcut_pkg;

    localparam int MEAN_W         = 16;
    localparam int DEFAULT_TARGET = 64;
    localparam int MIN_TARGET     = 16;
    localparam int BYTE_MAX       = 255;

    typedef enum logic [0:0] {
        CFG_TARGET    = 1'b0,
        CFG_THRESHOLD = 1'b1
    } t_cfg_addr;

    typedef enum logic {
        KIND_REGION  = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        logic insert;
        logic clear;
    } t_rank_ctrl;

endpackage

// ===== design/thumbcut_div.sv =====
module thumbcut_div #(
    parameter int DW = 25,
    parameter int VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_quo, n_quo;
    logic [VW-1:0]   r_rem, n_rem;
    logic [VW-1:0]   r_div, n_div;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_done, n_done;

    logic [VW:0]     w_shift;
    logic [VW:0]     w_diff;
    logic            w_ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_diff  = w_shift - {1'b0, r_div};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_div = i_divisor;
            n_cnt = CNTW'(DW);
        end else if (r_cnt != '0) begin
            n_quo  = {r_quo[DW-2:0], w_ge};
            n_rem  = w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNTW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/thumbcut_rank.sv =====
module thumbcut_rank #(
    parameter  int TOP_COUNT = 3,
    localparam int RW        = $clog2(TOP_COUNT + 1),
    localparam int IW        = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  thumbcut_pkg::t_rank_ctrl i_ctrl,
    input  logic [15:0]             i_mean,
    input  logic [IW-1:0]           i_rd_idx,
    output logic [15:0]             o_rd_mean,
    output logic [RW-1:0]           o_seen
);

    import thumbcut_pkg::*;

    logic [MEAN_W-1:0] r_top [TOP_COUNT];
    logic [MEAN_W-1:0] n_top [TOP_COUNT];
    logic [RW-1:0]     r_seen, n_seen;
    logic [TOP_COUNT-1:0] w_take;

    // entries kept in descending order, new mean goes to the first place it beats
    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            w_take[i] = (RW'(i) >= r_seen) || (i_mean > r_top[i]);
        end
        for (int i = 0; i < TOP_COUNT; i++) begin
            n_top[i] = r_top[i];
            if (i_ctrl.insert && w_take[i]) begin
                if (i == 0) begin
                    n_top[i] = i_mean;
                end else if (!w_take[i-1]) begin
                    n_top[i] = i_mean;
                end else begin
                    n_top[i] = r_top[i-1];
                end
            end
        end
        n_seen = r_seen;
        if (i_ctrl.clear) begin
            n_seen = '0;
        end else if (i_ctrl.insert && (r_seen != RW'(TOP_COUNT))) begin
            n_seen = r_seen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            r_top[i] <= n_top[i];
        end
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

    assign o_rd_mean = r_top[i_rd_idx];
    assign o_seen    = r_seen;

endmodule

// ===== design/thumbnail_cut_scorer_unit.sv =====
// Sampled mean absolute difference of two gray thumbnails, region by region, for scene-cut
// detection. Each input item carries one pair of bytes; a region result (kind 0) follows the
// last byte of every region and a summary (kind 1, tlast) follows the last byte of a set.
// Everything runs through one shared restoring divider that produces one quotient bit per
// cycle, so the item rate is set by that divider and a small sequencer: an ordinary byte
// passes S_IDLE and S_SAMPLE, the first byte of a region adds the stride division, a region
// end adds the mean division, and a set end adds the sum of the kept means and the score
// division. The divider width is 17+FRAC_BITS bits at the default sizes.
// s_axis_tready is low while an item is being worked on; a finished result waits in the
// output register without holding up the next item unless that item has a result too.
// Users write configuration via the cfg port only while idle; the block does not enforce it.
`include "thumbnail_cut_scorer_unit_defines.svh"

module thumbnail_cut_scorer_unit #(
    parameter int MAX_SAMPLES = 256,
    parameter int TOP_COUNT   = 3,
    parameter int FRAC_BITS   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  thumbcut_pkg::t_cfg_addr  i_cfg_addr,
    input  logic [15:0]              i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // left_byte, right_byte, region_length
    input  logic [31:0]              s_axis_tdata,
    // set_end
    input  logic                     s_axis_tlast,
    // region_end
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // region_delta, is_hit, score, hit_count, zero fill
    output logic [55:0]              m_axis_tdata,
    // last
    output logic                     m_axis_tlast,
    // kind
    output logic                     m_axis_tuser
);

    import thumbcut_pkg::*;

    localparam int TW        = $clog2(MAX_SAMPLES + 1);
    localparam int COUNT_MAX = 2 * MAX_SAMPLES - 1;
    localparam int CW        = $clog2(2 * MAX_SAMPLES);
    localparam int SUM_MAX   = COUNT_MAX * BYTE_MAX;
    localparam int SW        = $clog2(SUM_MAX + 1);
    localparam int RW        = $clog2(TOP_COUNT + 1);
    localparam int IW        = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int ACW       = MEAN_W + RW;
    localparam int MDW       = SW + FRAC_BITS;
    localparam int DW        = (MDW > ACW) ? MDW : ACW;
    localparam int VW0       = (CW > RW) ? CW : RW;
    localparam int VW        = (VW0 > TW) ? VW0 : TW;
    localparam int CAP_RAW   = BYTE_MAX << FRAC_BITS;
    localparam int CAP_INT   = (CAP_RAW > 65535) ? 65535 : CAP_RAW;
    localparam logic [DW-1:0] MEAN_CAP = DW'(CAP_INT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_STRIDE,
        S_SAMPLE,
        S_MEAN_GO,
        S_DIV_MEAN,
        S_REGION,
        S_PUT_REGION,
        S_SUM,
        S_SCORE_GO,
        S_DIV_SCORE,
        S_PUT_SUM
    } t_state;

    // configuration
    logic [9:0]  r_target;
    logic [15:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 10'(DEFAULT_TARGET);
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TARGET:    r_target    <= i_cfg_wdata[9:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                default:       r_target    <= r_target;
            endcase
        end
    end

    logic [10:0]   w_tgt_a;
    logic [10:0]   w_tgt_b;
    logic [TW-1:0] w_target;

    always_comb begin
        w_tgt_a = (r_target == '0) ? 11'(DEFAULT_TARGET) : {1'b0, r_target};
        w_tgt_b = (w_tgt_a < 11'(MIN_TARGET)) ? 11'(MIN_TARGET) : w_tgt_a;
        if (w_tgt_b > 11'(MAX_SAMPLES)) begin
            w_tgt_b = 11'(MAX_SAMPLES);
        end
        w_target = w_tgt_b[TW-1:0];
    end

    // state
    t_state          r_state, n_state;
    logic            r_started, n_started;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_next, n_next;
    logic [15:0]     r_stride, n_stride;
    logic [SW-1:0]   r_sum, n_sum;
    logic [CW-1:0]   r_cnt_s, n_cnt_s;
    logic [15:0]     r_tally, n_tally;
    logic [RW-1:0]   r_idx, n_idx;
    logic [7:0]      r_lb, n_lb;
    logic [7:0]      r_rb, n_rb;
    logic            r_rend, n_rend;
    logic            r_send, n_send;
    logic [15:0]     r_mean, n_mean;
    logic            r_hit, n_hit;
    logic [ACW-1:0]  r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    t_kind           r_out_kind, n_out_kind;
    logic [15:0]     r_out_delta, n_out_delta;
    logic            r_out_hit, n_out_hit;
    logic [15:0]     r_out_score, n_out_score;
    logic [15:0]     r_out_hits, n_out_hits;
    logic            r_out_last, n_out_last;

    logic            w_in_acc;
    logic            w_out_free;
    logic            w_out_load;
    logic [7:0]      w_absd;
    logic [SW:0]     w_sum_add;
    logic            w_div_start;
    logic [DW-1:0]   w_div_dividend;
    logic [VW-1:0]   w_div_divisor;
    logic            w_div_done;
    logic [DW-1:0]   w_div_q;
    t_rank_ctrl      w_rank_ctrl;
    logic [15:0]     w_rd_mean;
    logic [RW-1:0]   w_seen;
    logic            w_div_wait;
    logic [SW+7:0]   w_sum_bound;

    thumbcut_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    thumbcut_rank #(
        .TOP_COUNT (TOP_COUNT)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_rank_ctrl),
        .i_mean    (r_mean),
        .i_rd_idx  (r_idx[IW-1:0]),
        .o_rd_mean (w_rd_mean),
        .o_seen    (w_seen)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        w_absd    = (r_lb > r_rb) ? (r_lb - r_rb) : (r_rb - r_lb);
        w_sum_add = {1'b0, r_sum} + (SW + 1)'(w_absd);

        n_state     = r_state;
        n_started   = r_started;
        n_pos       = r_pos;
        n_next      = r_next;
        n_stride    = r_stride;
        n_sum       = r_sum;
        n_cnt_s     = r_cnt_s;
        n_tally     = r_tally;
        n_idx       = r_idx;
        n_lb        = r_lb;
        n_rb        = r_rb;
        n_rend      = r_rend;
        n_send      = r_send;
        n_mean      = r_mean;
        n_hit       = r_hit;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_delta = r_out_delta;
        n_out_hit   = r_out_hit;
        n_out_score = r_out_score;
        n_out_hits  = r_out_hits;
        n_out_last  = r_out_last;

        w_out_load     = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        w_rank_ctrl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_lb   = s_axis_tdata[7:0];
                    n_rb   = s_axis_tdata[15:8];
                    n_rend = s_axis_tuser;
                    n_send = s_axis_tlast;
                    if (!r_started) begin
                        w_div_start    = 1'b1;
                        w_div_dividend = DW'(s_axis_tdata[31:16]);
                        w_div_divisor  = VW'(w_target);
                        n_state        = S_DIV_STRIDE;
                    end else begin
                        n_state = S_SAMPLE;
                    end
                end
            end
            S_DIV_STRIDE: begin
                if (w_div_done) begin
                    n_stride  = (w_div_q == '0) ? 16'd1 : w_div_q[15:0];
                    n_started = 1'b1;
                    n_state   = S_SAMPLE;
                end
            end
            S_SAMPLE: begin
                if (r_pos == r_next) begin
                    n_sum = (w_sum_add > (SW + 1)'(SUM_MAX)) ? SW'(SUM_MAX)
                                                             : w_sum_add[SW-1:0];
                    if (r_cnt_s < CW'(COUNT_MAX)) begin
                        n_cnt_s = r_cnt_s + 1'b1;
                    end
                    n_next = r_next + r_stride;
                end
                n_pos   = r_pos + 16'd1;
                n_state = (r_rend || r_send) ? S_MEAN_GO : S_IDLE;
            end
            S_MEAN_GO: begin
                if (r_cnt_s != '0) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = DW'(r_sum) << FRAC_BITS;
                    w_div_divisor  = VW'(r_cnt_s);
                    n_state        = S_DIV_MEAN;
                end else begin
                    n_mean  = '0;
                    n_state = S_REGION;
                end
            end
            S_DIV_MEAN: begin
                if (w_div_done) begin
                    n_mean  = (w_div_q > MEAN_CAP) ? MEAN_CAP[15:0] : w_div_q[15:0];
                    n_state = S_REGION;
                end
            end
            S_REGION: begin
                n_hit = (r_mean >= r_threshold);
                if (n_hit && (r_tally != 16'hFFFF)) begin
                    n_tally = r_tally + 16'd1;
                end
                w_rank_ctrl.insert = 1'b1;
                n_state            = S_PUT_REGION;
            end
            S_PUT_REGION: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_REGION;
                    n_out_delta = r_mean;
                    n_out_hit   = r_hit;
                    n_out_score = '0;
                    n_out_hits  = '0;
                    n_out_last  = 1'b0;
                    n_started   = 1'b0;
                    n_pos       = '0;
                    n_next      = '0;
                    n_stride    = '0;
                    n_sum       = '0;
                    n_cnt_s     = '0;
                    n_idx       = '0;
                    n_acc       = '0;
                    n_state     = r_send ? S_SUM : S_IDLE;
                end
            end
            S_SUM: begin
                if (r_idx < w_seen) begin
                    n_acc = r_acc + ACW'(w_rd_mean);
                    n_idx = r_idx + 1'b1;
                end else if (w_seen == '0) begin
                    n_mean  = '0;
                    n_state = S_PUT_SUM;
                end else begin
                    n_state = S_SCORE_GO;
                end
            end
            S_SCORE_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = DW'(r_acc);
                w_div_divisor  = VW'(w_seen);
                n_state        = S_DIV_SCORE;
            end
            S_DIV_SCORE: begin
                if (w_div_done) begin
                    n_mean  = w_div_q[15:0];
                    n_state = S_PUT_SUM;
                end
            end
            S_PUT_SUM: begin
                if (w_out_free) begin
                    w_out_load        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out_kind        = KIND_SUMMARY;
                    n_out_delta       = '0;
                    n_out_hit         = 1'b0;
                    n_out_score       = r_mean;
                    n_out_hits        = r_tally;
                    n_out_last        = 1'b1;
                    n_tally           = '0;
                    w_rank_ctrl.clear = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lb        <= n_lb;
        r_rb        <= n_rb;
        r_rend      <= n_rend;
        r_send      <= n_send;
        r_mean      <= n_mean;
        r_hit       <= n_hit;
        r_acc       <= n_acc;
        r_out_kind  <= n_out_kind;
        r_out_delta <= n_out_delta;
        r_out_hit   <= n_out_hit;
        r_out_score <= n_out_score;
        r_out_hits  <= n_out_hits;
        r_out_last  <= n_out_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_pos       <= '0;
            r_next      <= '0;
            r_stride    <= '0;
            r_sum       <= '0;
            r_cnt_s     <= '0;
            r_tally     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_pos       <= n_pos;
            r_next      <= n_next;
            r_stride    <= n_stride;
            r_sum       <= n_sum;
            r_cnt_s     <= n_cnt_s;
            r_tally     <= n_tally;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_hits, r_out_score, r_out_hit, r_out_delta};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_kind;

    assign w_div_wait  = (r_state == S_DIV_STRIDE) || (r_state == S_DIV_MEAN) ||
                         (r_state == S_DIV_SCORE);
    assign w_sum_bound = (SW + 8)'(r_cnt_s) * (SW + 8)'(BYTE_MAX);

    // divider results only turn up where the sequencer waits for them
    `TCS_ASSERT(a_div_done_state, i_clk, i_rst_n, w_div_done |-> w_div_wait, "stray divider result")
    `TCS_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_out_load && !w_out_free, "result overwritten")
    `TCS_ASSERT(a_count_bound, i_clk, i_rst_n, r_cnt_s <= CW'(COUNT_MAX), "sample count too high")
    `TCS_ASSERT(a_sum_bound, i_clk, i_rst_n, (SW + 8)'(r_sum) <= w_sum_bound, "sum too large")

endmodule
